/* hw/rtl/amrf_pkg.sv */
// ----------------------------------------------------------------------------
// amrf_pkg
// Shared types and constants of the audio mixer and register file unit:
// command codes, the register map and the fixed field widths.
// ----------------------------------------------------------------------------
package amrf_pkg;

	// Command carried in tuser of the input word.
	typedef enum logic [2:0] {
		CMD_READ     = 3'd0,
		CMD_WRITE    = 3'd1,
		CMD_RAISE    = 3'd2,
		CMD_SPR_DONE = 3'd3,
		CMD_MIX      = 3'd4
	} cmd_t;

	// Register map within the chip page.
	localparam logic [7:0] ADDR_ATTEN_BASE = 8'h40;
	localparam logic [7:0] ADDR_PAN        = 8'h44;
	localparam logic [7:0] ADDR_STEREO     = 8'h50;
	localparam logic [7:0] ADDR_IRQ_RST    = 8'h80;
	localparam logic [7:0] ADDR_IRQ_SET    = 8'h81;
	localparam logic [7:0] ADDR_HW_REV     = 8'h88;
	localparam logic [7:0] ADDR_SPR_ACK    = 8'h90;
	localparam logic [7:0] ADDR_CPU_SLEEP  = 8'h91;
	localparam logic [7:0] ADDR_DISP_LO    = 8'h94;
	localparam logic [7:0] ADDR_DISP_HI    = 8'h95;
	localparam logic [7:0] ADDR_PAL_BASE   = 8'ha0;

	// Fixed values.
	localparam logic [7:0] HW_REVISION     = 8'h01;
	localparam logic [7:0] REG_UNMAPPED    = 8'hff;
	localparam logic [7:0] REG_ALL_ONES    = 8'hff;
	localparam logic [7:0] DISP_LO_MASK    = 8'hfc;
	localparam logic [7:0] SERIAL_IRQ_MASK = 8'h10;
	localparam logic [7:0] GREEN_MASK      = 8'h0f;
	localparam logic [5:0] GAIN_NEUTRAL    = 6'h3c;
	localparam int         PAL_GREEN_ENTRIES = 16;
	localparam int         MAX_CHANNELS    = 4;

	// Datapath widths.
	localparam int SAMPLE_W    = 8;
	localparam int PROD_W      = 14;
	localparam int MIX_W       = 16;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 64;

endpackage

/* hw/rtl/amrf_palette_ram.sv */
// ----------------------------------------------------------------------------
// amrf_palette_ram
// Palette memory with one write port and one registered read port. Each
// entry has a valid bit cleared by reset; an entry never written reads 0xff.
// ----------------------------------------------------------------------------
module amrf_palette_ram #(
	parameter int ENTRIES = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [$clog2(ENTRIES)-1:0] wr_idx,
	input  logic [7:0]                 wr_data,
	input  logic                       rd_en,
	input  logic [$clog2(ENTRIES)-1:0] rd_idx,
	output logic [7:0]                 rd_data
);

	logic [7:0]         mem [ENTRIES];
	logic [ENTRIES-1:0] written_q;
	logic [7:0]         rd_word_q;
	logic               rd_written_q;

	// Valid bits: reset marks every entry as holding its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_idx];
			end
		end
	end

	// Storage array and registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q <= mem[rd_idx];
		end
	end

	assign rd_data = rd_written_q ? rd_word_q : amrf_pkg::REG_ALL_ONES;

endmodule

/* hw/rtl/audio_mixer_and_register_file_unit.sv */
// ----------------------------------------------------------------------------
// audio_mixer_and_register_file_unit
// Register file and stereo mixer of a handheld system chip: bus reads and
// writes, interrupt raise, sprite-done events and four-channel audio mixing.
// ----------------------------------------------------------------------------
// Path: an input word taken is registered in stage 1, then in the output register,
// from which its result word is offered on the output stream.
// Throughput: one word per cycle; the palette memory port and the per-channel
// multipliers are each used once per word, and the pipeline stalls only when
// the output register is full and not taken.
// Reset: asynchronous, active low; registers return to their reset values and
// palette entries read 0xff until written, with no clearing pass.
// ----------------------------------------------------------------------------
module audio_mixer_and_register_file_unit #(
	parameter int PALETTE_ENTRIES = 32,
	parameter int AUDIO_CHANNELS  = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata, low bit up: address[7:0], data[15:8], sample_ch0[23:16],
	// sample_ch1[31:24], sample_ch2[39:32], sample_ch3[47:40],
	// serial_irq_active[48], zero fill[55:49].
	input  logic [55:0] s_axis_tdata,
	// tuser: command[2:0].
	input  logic [2:0]  s_axis_tuser,
	// Output stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata, low bit up: read_data[7:0], mix_left[23:8], mix_right[39:24],
	// irq_line[40], start_sprites[41], display_address[57:42], zero fill[63:58].
	output logic [63:0] m_axis_tdata
);

	localparam int IDX_W = $clog2(PALETTE_ENTRIES);

	// Input word fields.
	amrf_pkg::cmd_t     cmd;
	logic [7:0]         addr;
	logic [7:0]         wdata;
	logic               serial_active;
	logic signed [amrf_pkg::SAMPLE_W-1:0] smp [amrf_pkg::MAX_CHANNELS];

	assign cmd           = amrf_pkg::cmd_t'(s_axis_tuser);
	assign addr          = s_axis_tdata[7:0];
	assign wdata         = s_axis_tdata[15:8];
	assign smp[0]        = s_axis_tdata[23:16];
	assign smp[1]        = s_axis_tdata[31:24];
	assign smp[2]        = s_axis_tdata[39:32];
	assign smp[3]        = s_axis_tdata[47:40];
	assign serial_active = s_axis_tdata[48];

	// Architectural registers.
	logic [7:0]  atten_q [AUDIO_CHANNELS];
	logic [7:0]  pan_q;
	logic [7:0]  stereo_q;
	logic [7:0]  irq_q;
	logic [15:0] disp_q;
	logic        spr_done_q;

	// Pipeline handshake.
	logic s1_valid_s1;
	logic out_valid_q;
	logic out_ready;
	logic accept;

	assign out_ready     = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !s1_valid_s1 || out_ready;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Decode of the register and palette regions.
	logic             is_read;
	logic             is_write;
	logic             is_mix;
	logic [7:0]       pal_off;
	logic             pal_hit;
	logic [IDX_W-1:0] pal_idx;

	assign is_read  = (cmd == amrf_pkg::CMD_READ);
	assign is_write = (cmd == amrf_pkg::CMD_WRITE);
	assign is_mix   = (cmd == amrf_pkg::CMD_MIX);
	assign pal_off  = addr - amrf_pkg::ADDR_PAL_BASE;
	assign pal_hit  = (addr >= amrf_pkg::ADDR_PAL_BASE) &&
		(pal_off < 8'(PALETTE_ENTRIES));
	assign pal_idx  = pal_off[IDX_W-1:0];

	// Next values of the interrupt flags, sprite flag and display base.
	logic [7:0]  irq_nxt;
	logic [7:0]  clr_mask;
	logic        spr_nxt;
	logic [15:0] disp_nxt;
	logic        start_nxt;

	always_comb begin
		irq_nxt   = irq_q;
		spr_nxt   = spr_done_q;
		disp_nxt  = disp_q;
		start_nxt = 1'b0;
		clr_mask  = serial_active ? (wdata & ~amrf_pkg::SERIAL_IRQ_MASK) : wdata;
		case (cmd)
			amrf_pkg::CMD_WRITE: begin
				case (addr)
					amrf_pkg::ADDR_IRQ_RST:   irq_nxt = irq_q & ~clr_mask;
					amrf_pkg::ADDR_IRQ_SET:   irq_nxt = irq_q | wdata;
					amrf_pkg::ADDR_SPR_ACK:   spr_nxt = 1'b0;
					amrf_pkg::ADDR_CPU_SLEEP: start_nxt = !spr_done_q && (irq_q == 8'h00);
					amrf_pkg::ADDR_DISP_LO:   disp_nxt = {disp_q[15:8], wdata & amrf_pkg::DISP_LO_MASK};
					amrf_pkg::ADDR_DISP_HI:   disp_nxt = {wdata, disp_q[7:0]};
					default: begin
					end
				endcase
			end
			amrf_pkg::CMD_RAISE:    irq_nxt = irq_q | wdata;
			amrf_pkg::CMD_SPR_DONE: spr_nxt = 1'b1;
			default: begin
			end
		endcase
	end

	// Register read mux for everything outside the palette.
	logic [7:0] rd_reg;

	always_comb begin
		rd_reg = amrf_pkg::REG_UNMAPPED;
		case (addr)
			amrf_pkg::ADDR_PAN:     rd_reg = pan_q;
			amrf_pkg::ADDR_STEREO:  rd_reg = stereo_q;
			amrf_pkg::ADDR_IRQ_RST: rd_reg = irq_q;
			amrf_pkg::ADDR_IRQ_SET: rd_reg = irq_q;
			amrf_pkg::ADDR_HW_REV:  rd_reg = amrf_pkg::HW_REVISION;
			default: begin
			end
		endcase
		for (int i = 0; i < AUDIO_CHANNELS; i++) begin
			if (addr == amrf_pkg::ADDR_ATTEN_BASE + 8'(i)) begin
				rd_reg = atten_q[i];
			end
		end
		if (!is_read) begin
			rd_reg = amrf_pkg::REG_UNMAPPED;
		end
	end

	// Channel products: one multiplier per channel and side.
	logic signed [amrf_pkg::PROD_W-1:0] prod_l [AUDIO_CHANNELS];
	logic signed [amrf_pkg::PROD_W-1:0] prod_r [AUDIO_CHANNELS];

	always_comb begin
		logic [5:0]                         gl;
		logic [5:0]                         gr;
		logic signed [amrf_pkg::PROD_W-1:0] sx;
		for (int i = 0; i < AUDIO_CHANNELS; i++) begin
			gl = pan_q[i] ? {atten_q[i][7:4], 2'b00} : amrf_pkg::GAIN_NEUTRAL;
			gr = pan_q[i] ? {atten_q[i][3:0], 2'b00} : amrf_pkg::GAIN_NEUTRAL;
			sx = {{(amrf_pkg::PROD_W - amrf_pkg::SAMPLE_W){smp[i][7]}}, smp[i]};
			prod_l[i] = '0;
			prod_r[i] = '0;
			if (is_mix && !stereo_q[i]) begin
				prod_l[i] = sx * $signed({{(amrf_pkg::PROD_W - 6){1'b0}}, gl});
			end
			if (is_mix && !stereo_q[4 + i]) begin
				prod_r[i] = sx * $signed({{(amrf_pkg::PROD_W - 6){1'b0}}, gr});
			end
		end
	end

	// Architectural register updates on each accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AUDIO_CHANNELS; i++) begin
				atten_q[i] <= amrf_pkg::REG_ALL_ONES;
			end
			pan_q      <= amrf_pkg::REG_ALL_ONES;
			stereo_q   <= '0;
			irq_q      <= '0;
			disp_q     <= '0;
			spr_done_q <= 1'b0;
		end else if (accept) begin
			irq_q      <= irq_nxt;
			disp_q     <= disp_nxt;
			spr_done_q <= spr_nxt;
			if (is_write) begin
				for (int i = 0; i < AUDIO_CHANNELS; i++) begin
					if (addr == amrf_pkg::ADDR_ATTEN_BASE + 8'(i)) begin
						atten_q[i] <= wdata;
					end
				end
				if (addr == amrf_pkg::ADDR_PAN) begin
					pan_q <= wdata;
				end
				if (addr == amrf_pkg::ADDR_STEREO) begin
					stereo_q <= wdata;
				end
			end
		end
	end

	// Palette memory: written and read at the cycle the word is taken.
	logic [7:0] pal_rdata;

	amrf_palette_ram #(
		.ENTRIES(PALETTE_ENTRIES)
	) u_palette (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && is_write && pal_hit),
		.wr_idx  (pal_idx),
		.wr_data (wdata),
		.rd_en   (accept && is_read && pal_hit),
		.rd_idx  (pal_idx),
		.rd_data (pal_rdata)
	);

	// Stage 1: products, decoded read value and post-step status.
	logic        pal_rd_s1;
	logic        green_s1;
	logic [7:0]  rd_s1;
	logic        irq_s1;
	logic        start_s1;
	logic [15:0] disp_s1;
	logic signed [amrf_pkg::PROD_W-1:0] prod_l_s1 [AUDIO_CHANNELS];
	logic signed [amrf_pkg::PROD_W-1:0] prod_r_s1 [AUDIO_CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pal_rd_s1 <= is_read && pal_hit;
			green_s1  <= pal_off < 8'(amrf_pkg::PAL_GREEN_ENTRIES);
			rd_s1     <= rd_reg;
			irq_s1    <= irq_nxt != 8'h00;
			start_s1  <= start_nxt;
			disp_s1   <= disp_nxt;
			for (int i = 0; i < AUDIO_CHANNELS; i++) begin
				prod_l_s1[i] <= prod_l[i];
				prod_r_s1[i] <= prod_r[i];
			end
		end
	end

	// Stage 2: channel sums and palette read data into the output register.
	logic signed [amrf_pkg::MIX_W-1:0] sum_l;
	logic signed [amrf_pkg::MIX_W-1:0] sum_r;
	logic [7:0]                        rd_fin;

	always_comb begin
		sum_l = '0;
		sum_r = '0;
		for (int i = 0; i < AUDIO_CHANNELS; i++) begin
			sum_l = sum_l + amrf_pkg::MIX_W'(prod_l_s1[i]);
			sum_r = sum_r + amrf_pkg::MIX_W'(prod_r_s1[i]);
		end
		rd_fin = rd_s1;
		if (pal_rd_s1) begin
			rd_fin = green_s1 ? (pal_rdata & amrf_pkg::GREEN_MASK) : pal_rdata;
		end
	end

	logic [63:0] out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && s1_valid_s1) begin
			out_word_q <= {6'b0, disp_s1, start_s1, irq_s1, sum_r, sum_l, rd_fin};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_word_q;

	// Input is refused only while a finished word is waiting downstream.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without a pending output word");

	// A word held in stage 1 is not lost while the output is blocked.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && !out_ready) |=> s1_valid_s1)
		else $error("stage 1 word dropped during stall");

	// A start-sprites pulse comes from a bus write, never from a mix word.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[41]) |->
			(m_axis_tdata[39:8] == 32'h0 && m_axis_tdata[7:0] == amrf_pkg::REG_UNMAPPED))
		else $error("start-sprites pulse on a non-write word");

endmodule

/* verif/mixer_regfile_checker.sv */
// ----------------------------------------------------------------------------
// mixer_regfile_checker
// Watches both streams of the audio mixer and register file unit. It mirrors
// the register state, works out the result word owed for every input word
// taken, and compares each result word taken, field by field, in order.
// ----------------------------------------------------------------------------
module mixer_regfile_checker
	import amrf_pkg::*;
#(
	parameter int PALETTE_ENTRIES = 32,
	parameter int AUDIO_CHANNELS  = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	// Fields, low bit up: address, data, sample_ch0..3, serial_irq_active.
	input  logic [IN_TDATA_W-1:0]  in_data,
	// Fields: command.
	input  logic [2:0]             in_cmd,
	input  logic                   out_valid,
	input  logic                   out_ready,
	// Fields, low bit up: read_data, mix_left, mix_right, irq_line,
	// start_sprites, display_address.
	input  logic [OUT_TDATA_W-1:0] out_data,
	output int                     fail_count,
	output int                     awaited_count
);

	// One result word, unpacked.
	typedef struct packed {
		logic [7:0]         read_data;
		logic signed [15:0] mix_left;
		logic signed [15:0] mix_right;
		logic               irq_line;
		logic               start_sprites;
		logic [15:0]        display_address;
	} mix_reg_result_t;

	// Mirror of the register file.
	logic [7:0]      atten_shadow [MAX_CHANNELS];
	logic [5:0]      left_gain [MAX_CHANNELS];
	logic [5:0]      right_gain [MAX_CHANNELS];
	logic [7:0]      pan_shadow;
	logic [7:0]      stereo_off;
	logic [7:0]      irq_shadow;
	logic [7:0]      palette_shadow [32];
	logic [15:0]     disp_shadow;
	logic            sprites_finished;

	mix_reg_result_t awaited_words [$];
	int              checked_words;

	// Applies one input word to the mirror and returns the result it owes.
	function automatic mix_reg_result_t regfile_mix_step(input logic [2:0] cmd,
			input logic [7:0] addr, input logic [7:0] data, input logic [31:0] samples,
			input logic serial);
		mix_reg_result_t res;
		int              left;
		int              right;
		int              pal_idx;
		logic [7:0]      clear_mask;
		logic signed [7:0] smp;
		bit              atten_hit;
		bit              pal_hit;
		res.read_data     = REG_UNMAPPED;
		res.start_sprites = 1'b0;
		left              = 0;
		right             = 0;
		atten_hit = int'(addr) >= int'(ADDR_ATTEN_BASE)
			&& int'(addr) < int'(ADDR_ATTEN_BASE) + AUDIO_CHANNELS
			&& int'(addr) < int'(ADDR_PAN);
		pal_idx = int'(addr) - int'(ADDR_PAL_BASE);
		pal_hit = pal_idx >= 0 && pal_idx < PALETTE_ENTRIES && pal_idx < 32;
		case (cmd)
			CMD_READ: begin
				if (atten_hit) begin
					res.read_data = atten_shadow[addr[1:0]];
				end else if (addr == ADDR_PAN) begin
					res.read_data = pan_shadow;
				end else if (addr == ADDR_STEREO) begin
					res.read_data = stereo_off;
				end else if (addr == ADDR_IRQ_RST || addr == ADDR_IRQ_SET) begin
					res.read_data = irq_shadow;
				end else if (addr == ADDR_HW_REV) begin
					res.read_data = HW_REVISION;
				end else if (pal_hit) begin
					// Green entries show only their low nibble.
					res.read_data = (pal_idx < PAL_GREEN_ENTRIES)
						? (palette_shadow[pal_idx] & GREEN_MASK) : palette_shadow[pal_idx];
				end
			end
			CMD_WRITE: begin
				if (atten_hit) begin
					atten_shadow[addr[1:0]] = data;
					right_gain[addr[1:0]]   = {data[3:0], 2'b00};
					left_gain[addr[1:0]]    = {data[7:4], 2'b00};
				end else if (addr == ADDR_PAN) begin
					pan_shadow = data;
				end else if (addr == ADDR_STEREO) begin
					stereo_off = data;
				end else if (addr == ADDR_IRQ_RST) begin
					// A live serial source keeps its flag from being cleared.
					clear_mask = serial ? (data & ~SERIAL_IRQ_MASK) : data;
					irq_shadow = irq_shadow & ~clear_mask;
				end else if (addr == ADDR_IRQ_SET) begin
					irq_shadow = irq_shadow | data;
				end else if (addr == ADDR_SPR_ACK) begin
					sprites_finished = 1'b0;
				end else if (addr == ADDR_CPU_SLEEP) begin
					res.start_sprites = !sprites_finished && irq_shadow == '0;
				end else if (addr == ADDR_DISP_LO) begin
					disp_shadow = {disp_shadow[15:8], data & DISP_LO_MASK};
				end else if (addr == ADDR_DISP_HI) begin
					disp_shadow = {data, disp_shadow[7:0]};
				end else if (pal_hit) begin
					palette_shadow[pal_idx] = data;
				end
			end
			CMD_RAISE: begin
				irq_shadow = irq_shadow | data;
			end
			CMD_SPR_DONE: begin
				sprites_finished = 1'b1;
			end
			CMD_MIX: begin
				// Panned channels use their own gain, the rest the neutral one.
				for (int i = 0; i < AUDIO_CHANNELS && i < MAX_CHANNELS; i++) begin
					smp = samples[8*i +: 8];
					if (!stereo_off[i]) begin
						left += int'(smp) * int'(pan_shadow[i] ? left_gain[i] : GAIN_NEUTRAL);
					end
					if (!stereo_off[4+i]) begin
						right += int'(smp) * int'(pan_shadow[i] ? right_gain[i] : GAIN_NEUTRAL);
					end
				end
			end
			default: begin
			end
		endcase
		res.mix_left        = left[15:0];
		res.mix_right       = right[15:0];
		res.irq_line        = irq_shadow != '0;
		res.display_address = disp_shadow;
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			if (fail_count < 10) begin
				$display("word %0d: %s expected %h, got %h", checked_words, name, want, got);
			end
			fail_count++;
		end
	endfunction

	// Compare the result word taken, then predict for the input word taken.
	always @(posedge clk or negedge arst_n) begin
		mix_reg_result_t want;
		mix_reg_result_t got;
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				atten_shadow[i] = REG_ALL_ONES;
				left_gain[i]    = GAIN_NEUTRAL;
				right_gain[i]   = GAIN_NEUTRAL;
			end
			for (int i = 0; i < 32; i++) begin
				palette_shadow[i] = REG_ALL_ONES;
			end
			pan_shadow       = REG_ALL_ONES;
			stereo_off       = '0;
			irq_shadow       = '0;
			disp_shadow      = '0;
			sprites_finished = 1'b0;
			awaited_words.delete();
			checked_words    = 0;
			fail_count       = 0;
			awaited_count   <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got.read_data       = out_data[7:0];
				got.mix_left        = out_data[23:8];
				got.mix_right       = out_data[39:24];
				got.irq_line        = out_data[40];
				got.start_sprites   = out_data[41];
				got.display_address = out_data[57:42];
				if (awaited_words.size() == 0) begin
					if (fail_count < 10) begin
						$display("unexpected result word %h", out_data);
					end
					fail_count++;
				end else begin
					want = awaited_words.pop_front();
					check_field("read_data", 16'(want.read_data), 16'(got.read_data));
					check_field("mix_left", want.mix_left, got.mix_left);
					check_field("mix_right", want.mix_right, got.mix_right);
					check_field("irq_line", 16'(want.irq_line), 16'(got.irq_line));
					check_field("start_sprites", 16'(want.start_sprites),
						16'(got.start_sprites));
					check_field("display_address", want.display_address,
						got.display_address);
				end
				checked_words++;
			end
			if (in_valid && in_ready) begin
				awaited_words.push_back(regfile_mix_step(in_cmd, in_data[7:0], in_data[15:8],
					in_data[47:16], in_data[48]));
			end
			awaited_count <= awaited_words.size();
		end
	end

endmodule

/* verif/tb_audio_mixer_and_register_file_unit.sv */
// ----------------------------------------------------------------------------
// tb_audio_mixer_and_register_file_unit
// Drives bus reads and writes, interrupt and sprite events, mix words and
// ignored commands into the unit, first a directed set, then random words
// biased toward mapped registers, with random gaps and stalls on both sides.
// The checker beside the unit predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_audio_mixer_and_register_file_unit;
	import amrf_pkg::*;

	localparam int CLK_HALF       = 6;
	localparam int RESET_CYCLES   = 5;
	localparam int RANDOM_WORDS   = 1575;
	localparam int IDLE_PCT       = 25;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TIMEOUT_CYCLES = 100000;

	// Command codes the unit does not know.
	localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

	localparam logic [7:0] SAMPLE_MAX = 8'h7f;
	localparam logic [7:0] SAMPLE_MIN = 8'h80;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic [2:0]             s_axis_tuser  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// Stimulus asks for a quiet window and for one long output hold-off.
	logic quiet     = 1'b0;
	logic hold_req  = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;

	int fail_count;
	int awaited_count;

	audio_mixer_and_register_file_unit #(
		.PALETTE_ENTRIES(32),
		.AUDIO_CHANNELS (4)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	mixer_regfile_checker #(
		.PALETTE_ENTRIES(32),
		.AUDIO_CHANNELS (4)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_data      (s_axis_tdata),
		.in_cmd       (s_axis_tuser),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_data     (m_axis_tdata),
		.fail_count   (fail_count),
		.awaited_count(awaited_count)
	);

	always #CLK_HALF clk = ~clk;

	// Output side: random stalls, one long hold-off, none in the quiet window.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left     <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			m_axis_tready <= 1'b0;
			hold_left     <= HOLD_CYCLES;
			hold_done     <= 1'b1;
		end else if (quiet) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= $urandom_range(0, 99) >= IDLE_PCT;
		end
	end

	// Offers one word after a random gap and returns once it is taken.
	// Called right after a rising edge.
	task automatic send_word(input logic [2:0] cmd, input logic [7:0] addr,
			input logic [7:0] data, input logic [31:0] samples, input logic serial);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, serial, samples, data, addr};
		s_axis_tuser  <= cmd;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
	endtask

	// Stops offering and waits until every owed result word has come.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited_count != 0) begin
			@(posedge clk);
		end
	endtask

	// Mostly mapped registers, sometimes any offset in the page.
	function automatic logic [7:0] pick_address();
		int roll;
		roll = $urandom_range(0, 19);
		case (roll)
			0, 1, 2, 3: return ADDR_ATTEN_BASE + 8'(roll);
			4: return ADDR_PAN;
			5: return ADDR_STEREO;
			6: return ADDR_IRQ_RST;
			7: return ADDR_IRQ_SET;
			8: return ADDR_HW_REV;
			9: return ADDR_SPR_ACK;
			10: return ADDR_CPU_SLEEP;
			11: return ADDR_DISP_LO;
			12: return ADDR_DISP_HI;
			13, 14, 15: return ADDR_PAL_BASE + 8'($urandom_range(0, 31));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic random_word();
		logic [2:0]  cmd;
		logic [7:0]  addr;
		logic [7:0]  data;
		logic [31:0] samples;
		int          roll;
		int          target;
		roll   = $urandom_range(0, 99);
		target = $urandom_range(0, 9);
		addr   = pick_address();
		data   = 8'($urandom_range(0, 255));
		for (int i = 0; i < MAX_CHANNELS; i++) begin
			samples[8*i +: 8] = pick_sample();
		end
		if (roll < 30) begin
			cmd = CMD_MIX;
		end else if (roll < 60) begin
			cmd = CMD_WRITE;
			// Steer some writes at the interrupt and sprite handshake.
			if (target == 0) begin
				addr = ADDR_IRQ_RST;
				if ($urandom_range(0, 1) == 1) begin
					data = REG_ALL_ONES;
				end
			end else if (target == 1) begin
				addr = ADDR_SPR_ACK;
			end else if (target == 2) begin
				addr = ADDR_CPU_SLEEP;
			end
		end else if (roll < 88) begin
			cmd = CMD_READ;
		end else if (roll < 91) begin
			cmd = CMD_RAISE;
		end else if (roll < 94) begin
			cmd = CMD_SPR_DONE;
		end else begin
			cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
		end
		send_word(cmd, addr, data, samples, 1'($urandom_range(0, 1)));
	endtask

	task automatic directed_words();
		// Reset values, fixed and unmapped registers.
		send_word(CMD_READ, ADDR_HW_REV, '0, '0, 1'b0);
		send_word(CMD_READ, ADDR_ATTEN_BASE + 8'(MAX_CHANNELS - 1), '0, '0, 1'b0);
		send_word(CMD_READ, ADDR_PAL_BASE, '0, '0, 1'b0);
		send_word(CMD_READ, 8'hff, '0, '0, 1'b0);
		// Mixing at neutral gains, both sample extremes.
		send_word(CMD_MIX, '0, '0, {4{SAMPLE_MAX}}, 1'b0);
		send_word(CMD_MIX, '0, '0, {4{SAMPLE_MIN}}, 1'b0);
		// Attenuation extremes, then a pan that leaves channel 3 neutral.
		send_word(CMD_WRITE, ADDR_ATTEN_BASE, 8'h00, '0, 1'b0);
		send_word(CMD_WRITE, ADDR_ATTEN_BASE + 8'd1, 8'hf0, '0, 1'b0);
		send_word(CMD_WRITE, ADDR_ATTEN_BASE + 8'd2, 8'h0f, '0, 1'b0);
		send_word(CMD_WRITE, ADDR_PAN, 8'h07, '0, 1'b0);
		send_word(CMD_MIX, '0, '0, {SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX}, 1'b0);
		send_word(CMD_WRITE, ADDR_STEREO, 8'ha5, '0, 1'b0);
		send_word(CMD_MIX, '0, '0, {SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN}, 1'b0);
		// Pending interrupts block the sleep start; a live serial source keeps bit 4.
		send_word(CMD_RAISE, '0, REG_ALL_ONES, '0, 1'b0);
		send_word(CMD_WRITE, ADDR_CPU_SLEEP, '0, '0, 1'b0);
		send_word(CMD_WRITE, ADDR_IRQ_RST, REG_ALL_ONES, '0, 1'b1);
		send_word(CMD_READ, ADDR_IRQ_SET, '0, '0, 1'b0);
		send_word(CMD_WRITE, ADDR_IRQ_RST, REG_ALL_ONES, '0, 1'b0);
		// Sleep starts the sprite engine only while it is not done.
		send_word(CMD_WRITE, ADDR_CPU_SLEEP, '0, '0, 1'b0);
		send_word(CMD_SPR_DONE, '0, '0, '0, 1'b0);
		send_word(CMD_WRITE, ADDR_CPU_SLEEP, '0, '0, 1'b0);
		send_word(CMD_WRITE, ADDR_SPR_ACK, '0, '0, 1'b0);
		// Display address, low bits forced clear.
		send_word(CMD_WRITE, ADDR_DISP_LO, REG_ALL_ONES, '0, 1'b0);
		send_word(CMD_WRITE, ADDR_DISP_HI, REG_ALL_ONES, '0, 1'b0);
		// Last green entry keeps all bits but reads back its low nibble.
		send_word(CMD_WRITE, ADDR_PAL_BASE + 8'(PAL_GREEN_ENTRIES - 1), 8'hab, '0, 1'b0);
		send_word(CMD_READ, ADDR_PAL_BASE + 8'(PAL_GREEN_ENTRIES - 1), '0, '0, 1'b0);
		// An unknown command changes nothing.
		send_word(CMD_UNUSED_LAST, ADDR_IRQ_SET, REG_ALL_ONES, '0, 1'b0);
	endtask

	// Stimulus and verdict.
	initial begin
		repeat (RESET_CYCLES) begin
			@(posedge clk);
		end
		arst_n <= 1'b1;
		directed_words();
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == 300) begin
				hold_req <= 1'b1;
			end
			if (n == 800) begin
				drain_results();
			end
			quiet <= (n >= 1000 && n < 1300);
			random_word();
		end
		drain_results();
		repeat (SETTLE_CYCLES) begin
			@(posedge clk);
		end
		if (fail_count == 0 && awaited_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#(TIMEOUT_CYCLES * 2 * CLK_HALF);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/amrf_pkg.sv
hw/rtl/amrf_palette_ram.sv
hw/rtl/audio_mixer_and_register_file_unit.sv
verif/mixer_regfile_checker.sv
verif/tb_audio_mixer_and_register_file_unit.sv
